### src/tts_pkg.sv
package tts_pkg;

    localparam int MAX_TASKS   = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W       = $clog2(MAX_TASKS + 1);
    localparam int RCNT_W      = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int TICKS_W     = 29;
    localparam int SLOT_OUT_W  = 6;

    localparam logic [31:0] DIV10_MUL = 32'hCCCC_CCCD;
    localparam logic [SLOT_OUT_W-1:0] FULL_SLOT = SLOT_OUT_W'(MAX_TASKS % 64);

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_DEL  = 2'd2,
        CMD_DISP = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        RK_TICK    = 3'd0,
        RK_ADDED   = 3'd1,
        RK_FULL    = 3'd2,
        RK_DELETED = 3'd3,
        RK_DELFAIL = 3'd4,
        RK_DUE     = 3'd5,
        RK_NONE    = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_FULL = 2'd1,
        ERR_DEL  = 2'd2
    } err_t;

    typedef struct packed {
        logic [7:0]         tag;
        logic [TICKS_W-1:0] delay;
        logic [TICKS_W-1:0] period;
        logic [7:0]         pending;
    } slot_t;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             div_dly;
        logic             div_per;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             ev_en;
        logic [IDX_W-1:0] ev_addr;
        logic             op_tick;
        logic             cnt_last;
        logic             add_wr;
        logic             add_full;
        logic             del_do;
        logic             tick_done;
        logic             none_due;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic valid_at;
        logic nz_any;
        logic ev_emit;
        logic ev_last;
    } dp_sts_t;

    // exact floor(x / 10) for any 32-bit x
    function automatic logic [TICKS_W-1:0] div10(input logic [31:0] x);
        logic [63:0] p;
        p = x * DIV10_MUL;
        return p[63:35];
    endfunction

endpackage

### src/tts_ctrl.sv
module tts_ctrl import tts_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic [1:0] s_cmd,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DIVD  = 10'b00_0000_0010,
        S_DIVP  = 10'b00_0000_0100,
        S_ASCAN = 10'b00_0000_1000,
        S_AWR   = 10'b00_0001_0000,
        S_AFULL = 10'b00_0010_0000,
        S_DEL   = 10'b00_0100_0000,
        S_DCHK  = 10'b00_1000_0000,
        S_SCAN  = 10'b01_0000_0000,
        S_TEND  = 10'b10_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]    ev_idx_reg, ev_idx_next;
    logic                op_tick_reg, op_tick_next;
    logic [RCNT_W-1:0]   cnt_reg, cnt_next;
    logic                stall;

    assign s_tready = (state_reg == S_IDLE);
    assign stall    = ev_valid_reg && sts.ev_emit && !sts.out_free;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        ev_valid_next = ev_valid_reg;
        ev_idx_next   = ev_idx_reg;
        op_tick_next  = op_tick_reg;
        cnt_next      = cnt_reg;

        cmd           = '0;
        cmd.rd_addr   = idx_reg[IDX_W-1:0];
        cmd.ev_addr   = ev_idx_reg;
        cmd.op_tick   = op_tick_reg;
        cmd.cnt_last  = (cnt_reg == RCNT_W'(MAX_RESULTS - 1));

        unique case (state_reg)
            S_IDLE: begin
                idx_next      = '0;
                ev_valid_next = 1'b0;
                cnt_next      = '0;
                if (s_tvalid) begin
                    cmd.capture  = 1'b1;
                    op_tick_next = (cmd_t'(s_cmd) == CMD_TICK);
                    unique case (cmd_t'(s_cmd))
                        CMD_TICK: state_next = S_SCAN;
                        CMD_ADD:  state_next = S_DIVD;
                        CMD_DEL:  state_next = S_DEL;
                        CMD_DISP: state_next = S_DCHK;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_DIVD: begin
                cmd.div_dly = 1'b1;
                state_next  = S_DIVP;
            end
            S_DIVP: begin
                cmd.div_per = 1'b1;
                state_next  = S_ASCAN;
            end
            S_ASCAN: begin
                if (!sts.valid_at) begin
                    state_next = S_AWR;
                end else if (idx_reg == CNT_W'(MAX_TASKS - 1)) begin
                    state_next = S_AFULL;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_AWR: begin
                if (sts.out_free) begin
                    cmd.add_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_AFULL: begin
                if (sts.out_free) begin
                    cmd.add_full = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DEL: begin
                if (sts.out_free) begin
                    cmd.del_do = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DCHK: begin
                if (sts.nz_any) begin
                    state_next = S_SCAN;
                end else if (sts.out_free) begin
                    cmd.none_due = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN: begin
                // read of slot idx overlaps the update of the slot before it
                if (!stall) begin
                    cmd.ev_en = ev_valid_reg;
                    if (idx_reg < CNT_W'(MAX_TASKS)) begin
                        cmd.rd_en     = 1'b1;
                        idx_next      = idx_reg + 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = idx_reg[IDX_W-1:0];
                    end else begin
                        ev_valid_next = 1'b0;
                    end
                    if (ev_valid_reg && sts.ev_emit) begin
                        cnt_next = cnt_reg + 1'b1;
                        if (sts.ev_last) begin
                            state_next = S_IDLE;
                        end
                    end else if (idx_reg == CNT_W'(MAX_TASKS) && !ev_valid_reg) begin
                        state_next = op_tick_reg ? S_TEND : S_IDLE;
                    end
                end
            end
            S_TEND: begin
                if (sts.out_free) begin
                    cmd.tick_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            ev_valid_reg <= 1'b0;
            ev_idx_reg   <= '0;
            op_tick_reg  <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            ev_valid_reg <= ev_valid_next;
            ev_idx_reg   <= ev_idx_next;
            op_tick_reg  <= op_tick_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

### src/tts_dpath.sv
module tts_dpath import tts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctl_cmd_t              cmd,
    output dp_sts_t               sts,
    input  logic [7:0]            in_sel,
    input  logic [7:0]            in_tag,
    input  logic [31:0]           in_dly,
    input  logic [31:0]           in_per,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2:0]            m_kind,
    output logic [SLOT_OUT_W-1:0] m_slot,
    output logic [7:0]            m_tag,
    output logic [1:0]            m_err,
    output logic                  m_last
);

    logic [7:0]           sel_reg, tag_reg;
    logic [31:0]          dly_ms_reg, per_ms_reg;
    logic [TICKS_W-1:0]   dticks_reg, pticks_reg;
    logic [TICKS_W-1:0]   quot;

    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [MAX_TASKS-1:0] nz_reg, nz_next;
    logic [MAX_TASKS-1:0] above;
    err_t                 err_reg, err_next;

    slot_t                mem [MAX_TASKS];
    slot_t                rd_reg;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    slot_t                wr_data;
    slot_t                upd;
    logic [7:0]           pend_dec;
    logic [IDX_W-1:0]     del_addr;

    logic                  emit;
    kind_t                 o_kind;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic [7:0]            o_tag;
    logic                  o_last;

    logic                  m_tvalid_reg;
    logic [2:0]            m_kind_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic [7:0]            m_tag_reg;
    logic [1:0]            m_err_reg;
    logic                  m_last_reg;

    // shared divide-by-ten multiplier, delay first then period
    assign quot = div10(cmd.div_per ? per_ms_reg : dly_ms_reg);

    assign above        = (nz_reg >> cmd.ev_addr) >> 1;
    assign del_addr     = sel_reg[IDX_W-1:0];
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.valid_at = valid_reg[cmd.rd_addr];
    assign sts.nz_any   = |nz_reg;
    assign sts.ev_emit  = !cmd.op_tick && nz_reg[cmd.ev_addr];
    assign sts.ev_last  = cmd.cnt_last || (above == '0);

    always_comb begin
        valid_next = valid_reg;
        nz_next    = nz_reg;
        err_next   = err_reg;
        wr_en      = 1'b0;
        wr_addr    = cmd.ev_addr;
        wr_data    = rd_reg;
        upd        = rd_reg;
        pend_dec   = rd_reg.pending - 8'd1;
        emit       = 1'b0;
        o_kind     = RK_TICK;
        o_slot     = '0;
        o_tag      = '0;
        o_last     = 1'b1;

        if (cmd.ev_en && cmd.op_tick && valid_reg[cmd.ev_addr]) begin
            if (rd_reg.delay == '0) begin
                if (rd_reg.pending != 8'hFF) begin
                    upd.pending = rd_reg.pending + 8'd1;
                end
                nz_next[cmd.ev_addr] = 1'b1;
                if (rd_reg.period != '0) begin
                    upd.delay = rd_reg.period;
                end
            end else begin
                upd.delay = rd_reg.delay - 1'b1;
            end
            wr_en   = 1'b1;
            wr_data = upd;
        end

        if (cmd.ev_en && sts.ev_emit) begin
            emit   = 1'b1;
            o_kind = RK_DUE;
            o_slot = SLOT_OUT_W'(cmd.ev_addr);
            o_tag  = rd_reg.tag;
            o_last = sts.ev_last;
            if (rd_reg.period == '0) begin
                // one-shot task leaves the table with any extra runs
                valid_next[cmd.ev_addr] = 1'b0;
                nz_next[cmd.ev_addr]    = 1'b0;
            end else begin
                upd.pending          = pend_dec;
                wr_en                = 1'b1;
                wr_data              = upd;
                nz_next[cmd.ev_addr] = (pend_dec != 8'd0);
            end
        end

        if (cmd.add_wr) begin
            wr_en                 = 1'b1;
            wr_addr               = cmd.rd_addr;
            wr_data.tag           = tag_reg;
            wr_data.delay         = dticks_reg;
            wr_data.period        = pticks_reg;
            wr_data.pending       = 8'd0;
            valid_next[cmd.rd_addr] = 1'b1;
            nz_next[cmd.rd_addr]    = 1'b0;
            emit                  = 1'b1;
            o_kind                = RK_ADDED;
            o_slot                = SLOT_OUT_W'(cmd.rd_addr);
        end

        if (cmd.add_full) begin
            err_next = ERR_FULL;
            emit     = 1'b1;
            o_kind   = RK_FULL;
            o_slot   = FULL_SLOT;
        end

        if (cmd.del_do) begin
            emit   = 1'b1;
            o_slot = sel_reg[SLOT_OUT_W-1:0];
            if (sel_reg >= 8'(MAX_TASKS)) begin
                err_next = ERR_DEL;
                o_kind   = RK_DELFAIL;
            end else begin
                if (!valid_reg[del_addr]) begin
                    err_next = ERR_DEL;
                    o_kind   = RK_DELFAIL;
                end else begin
                    o_kind   = RK_DELETED;
                end
                valid_next[del_addr] = 1'b0;
                nz_next[del_addr]    = 1'b0;
            end
        end

        if (cmd.tick_done) begin
            emit   = 1'b1;
            o_kind = RK_TICK;
        end

        if (cmd.none_due) begin
            emit   = 1'b1;
            o_kind = RK_NONE;
        end
    end

    // slot store: fields of a slot that is not valid are never used
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sel_reg    <= in_sel;
            tag_reg    <= in_tag;
            dly_ms_reg <= in_dly;
            per_ms_reg <= in_per;
        end
        if (cmd.div_dly) begin
            dticks_reg <= quot;
        end
        if (cmd.div_per) begin
            pticks_reg <= quot;
        end
        if (emit) begin
            m_kind_reg <= o_kind;
            m_slot_reg <= o_slot;
            m_tag_reg  <= o_tag;
            m_err_reg  <= err_next;
            m_last_reg <= o_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            nz_reg       <= '0;
            err_reg      <= ERR_NONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            nz_reg    <= nz_next;
            err_reg   <= err_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_kind   = m_kind_reg;
    assign m_slot   = m_slot_reg;
    assign m_tag    = m_tag_reg;
    assign m_err    = m_err_reg;
    assign m_last   = m_last_reg;

    a_nz_implies_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (nz_reg & ~valid_reg) == '0)
        else $error("pending run on a free slot");

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> sts.out_free)
        else $error("result loaded over an untaken result");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid_reg)
        else $error("loaded result not presented");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != 2'd3) && (!cmd.ev_en || !cmd.add_wr))
        else $error("bad error code or overlapping slot commands");

endmodule

### src/tick_task_scheduler_table_core.sv
// Time-triggered task table with stream channels.
// Input transaction: s_tuser holds the command (tick, add, delete, dispatch);
// s_tdata carries slot_select, task_tag, delay_ms and period_ms.
// Output transactions: m_tuser holds the result kind, m_tdata the slot,
// the due tag and the sticky error; m_tlast marks the final result of a
// command. A dispatch gives one result per due slot in slot order, or one
// "none due" result; every other command gives exactly one result.
// An add converts delay and period, in that order, on the shared divide-by-ten
// multiplier, then scans the slots for the first free one; a delete gives its
// result directly. Tick and dispatch sweep the slot store (one read and one
// write port) one slot per cycle while the output is not stalled, the read of the
// next slot overlapping the write of the current one: a tick gives its result
// after the whole sweep; a dispatch ends with its last due slot, or with the
// "none due" result when none is due.
// The next command is taken the cycle after the final result is loaded.
// Reset clears all slot valid bits, pending flags and the sticky error; the
// store itself needs no clearing. One output register holds each result; a
// stalled receiver holds the sweep at the next due slot until it is taken.
module tick_task_scheduler_table_core import tts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // slot_select, task_tag, delay_ms, period_ms
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slot_number, due_tag, error_state
    output logic [2:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    ctl_cmd_t              cmd;
    dp_sts_t               sts;
    logic [SLOT_OUT_W-1:0] slot;
    logic [7:0]            tag;
    logic [1:0]            err;

    tts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    tts_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_sel   (s_tdata[7:0]),
        .in_tag   (s_tdata[15:8]),
        .in_dly   (s_tdata[47:16]),
        .in_per   (s_tdata[79:48]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_kind   (m_tuser),
        .m_slot   (slot),
        .m_tag    (tag),
        .m_err    (err),
        .m_last   (m_tlast)
    );

    assign m_tdata = {err, tag, slot};

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb import tts_pkg::*; ();

    localparam int QUIET_LIMIT = 3000;

    typedef struct {
        kind_t      kind;
        logic [5:0] slot;
        logic [7:0] tag;
        err_t       err;
        logic       last;
    } sched_result_t;

    // shadow copy of the task table; predicts every result a command produces
    class sched_scoreboard;
        bit                 used       [MAX_TASKS];
        logic [7:0]         tag_of     [MAX_TASKS];
        logic [TICKS_W-1:0] delay_left [MAX_TASKS];
        logic [TICKS_W-1:0] period_of  [MAX_TASKS];
        logic [7:0]         runs_owed  [MAX_TASKS];
        err_t               err_code;
        sched_result_t      due_q[$];
        int                 mismatches;
        int                 results_seen;
        int                 dispatched;
        int                 saturations;
        int                 cmd_count[4];

        function new();
            int i;
            for (i = 0; i < MAX_TASKS; i++) begin
                clear_slot(i);
            end
            err_code = ERR_NONE;
        endfunction

        function void clear_slot(int i);
            used[i]       = 1'b0;
            tag_of[i]     = '0;
            delay_left[i] = '0;
            period_of[i]  = '0;
            runs_owed[i]  = '0;
        endfunction

        function void push(kind_t kind, int slot, logic [7:0] tag);
            sched_result_t r;
            r.kind = kind;
            r.slot = 6'(slot);
            r.tag  = tag;
            r.err  = err_code;
            r.last = 1'b0;
            due_q.push_back(r);
        endfunction

        // called for every accepted command transaction
        function void note_command(cmd_t cmd, logic [79:0] data);
            logic [7:0]  sel;
            logic [7:0]  tag;
            logic [31:0] dms;
            logic [31:0] pms;
            int          i;
            int          n;
            int          free_idx;
            sel = data[7:0];
            tag = data[15:8];
            dms = data[47:16];
            pms = data[79:48];
            cmd_count[cmd]++;
            case (cmd)
                CMD_TICK: begin
                    for (i = 0; i < MAX_TASKS; i++) begin
                        if (used[i]) begin
                            if (delay_left[i] == 0) begin
                                if (runs_owed[i] != 8'hFF) begin
                                    runs_owed[i]++;
                                end else begin
                                    saturations++;
                                end
                                if (period_of[i] != 0) begin
                                    delay_left[i] = period_of[i];
                                end
                            end else begin
                                delay_left[i]--;
                            end
                        end
                    end
                    push(RK_TICK, 0, 8'h00);
                end
                CMD_ADD: begin
                    free_idx = -1;
                    for (i = 0; i < MAX_TASKS; i++) begin
                        if (!used[i] && free_idx < 0) begin
                            free_idx = i;
                        end
                    end
                    if (free_idx < 0) begin
                        err_code = ERR_FULL;
                        push(RK_FULL, MAX_TASKS, 8'h00);
                    end else begin
                        used[free_idx]       = 1'b1;
                        tag_of[free_idx]     = tag;
                        delay_left[free_idx] = TICKS_W'(dms / 32'd10);
                        period_of[free_idx]  = TICKS_W'(pms / 32'd10);
                        runs_owed[free_idx]  = '0;
                        push(RK_ADDED, free_idx, 8'h00);
                    end
                end
                CMD_DEL: begin
                    if (sel >= MAX_TASKS) begin
                        err_code = ERR_DEL;
                        push(RK_DELFAIL, sel, 8'h00);
                    end else if (!used[sel]) begin
                        err_code = ERR_DEL;
                        clear_slot(sel);
                        push(RK_DELFAIL, sel, 8'h00);
                    end else begin
                        clear_slot(sel);
                        push(RK_DELETED, sel, 8'h00);
                    end
                end
                default: begin
                    n = 0;
                    for (i = 0; i < MAX_TASKS && n < MAX_RESULTS; i++) begin
                        if (runs_owed[i] != 0) begin
                            push(RK_DUE, i, tag_of[i]);
                            n++;
                            dispatched++;
                            runs_owed[i]--;
                            // one-shot task leaves the table, leftover runs are dropped
                            if (period_of[i] == 0) begin
                                clear_slot(i);
                            end
                        end
                    end
                    if (n == 0) begin
                        push(RK_NONE, 0, 8'h00);
                    end
                end
            endcase
            due_q[due_q.size() - 1].last = 1'b1;
        endfunction

        // called for every accepted result transaction
        function void check_result(logic [2:0] kind, logic [5:0] slot, logic [7:0] tag,
                                   logic [1:0] err, logic last);
            sched_result_t want;
            results_seen++;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result kind %0d slot %0d tag %02h err %0d last %0b",
                             $realtime, kind, slot, tag, err, last);
                end
                return;
            end
            want = due_q.pop_front();
            if (want.kind !== kind || want.slot !== slot || want.tag !== tag ||
                want.err !== err || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch, expected kind %0d slot %0d tag %02h err %0d last %0b",
                             $realtime, want.kind, want.slot, want.tag, want.err, want.last);
                    $display("%0t:           got      kind %0d slot %0d tag %02h err %0d last %0b",
                             $realtime, kind, slot, tag, err, last);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // slot_select, task_tag, delay_ms, period_ms
    logic [1:0]  s_tuser  = '0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // slot_number, due_tag, error_state
    logic [2:0]  m_tuser;         // result_kind
    logic        m_tlast;

    sched_scoreboard sb;
    int burst_left  = 0;
    int quiet_count = 0;
    int rx_mode     = 0;
    int rx_left     = 0;
    int rx_count    = 0;

    tick_task_scheduler_table_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver: switches between always ready, coin flip, a periodic ready and long stalls
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_count <= rx_count + 1;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_count % 5 == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // results are checked before the command of the same edge is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tuser, m_tdata[5:0], m_tdata[13:6], m_tdata[15:14], m_tlast);
            end
            if (s_tvalid && s_tready) begin
                sb.note_command(cmd_t'(s_tuser), s_tdata);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_count <= 0;
            end else begin
                quiet_count <= quiet_count + 1;
            end
            if (quiet_count >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $realtime, QUIET_LIMIT, sb.due_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_cmd(input cmd_t cmd, input logic [7:0] sel, input logic [7:0] tag,
                            input logic [31:0] dms, input logic [31:0] pms);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pms, dms, tag, sel};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_ms(input bit for_period);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            return $urandom;
        end
        // under 10 ms rounds to zero ticks, i.e. one-shot for a period
        if (for_period && roll < 50) begin
            return $urandom_range(0, 9);
        end
        if (roll < 60) begin
            return 32'(10 * $urandom_range(0, 6) + ($urandom_range(0, 1) ? 9 : 0));
        end
        return $urandom_range(0, 70);
    endfunction

    task automatic random_add();
        send_cmd(CMD_ADD, 8'($urandom), 8'($urandom), pick_ms(1'b0), pick_ms(1'b1));
    endtask

    task automatic random_mix(input int count);
        int j;
        int roll;
        for (j = 0; j < count; j++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                send_cmd(CMD_TICK, 8'($urandom), 8'($urandom), $urandom, $urandom);
            end else if (roll < 60) begin
                random_add();
            end else if (roll < 75) begin
                send_cmd(CMD_DEL,
                         ($urandom_range(0, 9) == 0) ? 8'($urandom_range(MAX_TASKS, 255))
                                                     : 8'($urandom_range(0, MAX_TASKS - 1)),
                         8'($urandom), $urandom, $urandom);
            end else begin
                send_cmd(CMD_DISP, 8'($urandom), 8'($urandom), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part: empty table, zero delay, tag extremes, field extremes, delete errors
        send_cmd(CMD_DISP, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD,  8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_TICK, 8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_TICK, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_DISP, 8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_DISP, 8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_ADD,  8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD,  8'h12, 8'h5A, 32'd9, 32'd10);
        send_cmd(CMD_ADD,  8'h34, 8'hA5, 32'd25, 32'd19);
        send_cmd(CMD_ADD,  8'h56, 8'h3C, 32'd10, 32'd0);
        send_cmd(CMD_TICK, 8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_TICK, 8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_TICK, 8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_DISP, 8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_DEL,  8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_DEL,  8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_DEL,  8'd31, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_DEL,  8'd32, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_DEL,  8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_TICK, 8'h00, 8'h00, 32'd0, 32'd0);
        send_cmd(CMD_DISP, 8'h00, 8'h00, 32'd0, 32'd0);

        // pending count saturation: one-shot and a two-tick periodic task left to pile up
        send_cmd(CMD_ADD, 8'($urandom), 8'h77, 32'd0, 32'd0);
        send_cmd(CMD_ADD, 8'($urandom), 8'h88, 32'd3, 32'd10);
        repeat (260) send_cmd(CMD_TICK, 8'($urandom), 8'($urandom), $urandom, $urandom);
        send_cmd(CMD_DISP, 8'($urandom), 8'($urandom), $urandom, $urandom);
        send_cmd(CMD_DISP, 8'($urandom), 8'($urandom), $urandom, $urandom);
        send_cmd(CMD_TICK, 8'($urandom), 8'($urandom), $urandom, $urandom);
        send_cmd(CMD_DISP, 8'($urandom), 8'($urandom), $urandom, $urandom);

        // random part: a table-filling burst, then a mix of all commands
        repeat (34) random_add();
        random_mix(30);
        s_tvalid <= 1'b0;

        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("commands: %0d tick, %0d add, %0d delete, %0d dispatch; %0d results checked",
                 sb.cmd_count[CMD_TICK], sb.cmd_count[CMD_ADD], sb.cmd_count[CMD_DEL],
                 sb.cmd_count[CMD_DISP], sb.results_seen);
        $display("%0d task runs dispatched, %0d ticks hit a saturated count, %0d mismatches",
                 sb.dispatched, sb.saturations, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### tick_task_scheduler_table_core.f
src/tts_pkg.sv
src/tts_ctrl.sv
src/tts_dpath.sv
src/tick_task_scheduler_table_core.sv
test/tb.sv
